### hw/rtl/bslp_pkg.sv
// ----------------------------------------------------------------------------
// bslp_pkg - shared types and constants of the button scanner
// Scan modes, button codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package bslp_pkg;

  localparam int unsigned PollW  = 12;
  localparam int unsigned LongW  = 16;
  localparam int unsigned HoldW  = 12;
  localparam int unsigned WaitW  = 13;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CodeW  = 3;

  localparam logic [PollW-1:0] PollReset    = 12'd100;
  localparam logic [LongW-1:0] LongReset    = 16'd1000;
  localparam logic [HoldW-1:0] HoldoffReset = 12'd25;

  // one-hot scan modes
  typedef enum logic [2:0] {
    MODE_WAIT    = 3'b001,
    MODE_TIMING  = 3'b010,
    MODE_RELEASE = 3'b100
  } mode_e;

  typedef enum logic [CodeW-1:0] {
    CODE_NONE     = 3'd0,
    CODE_BACK     = 3'd1,
    CODE_MENU     = 3'd2,
    CODE_UP       = 3'd3,
    CODE_DOWN     = 3'd4,
    CODE_LONGBACK = 3'd5
  } code_e;

  typedef enum logic [1:0] {
    REG_POLL    = 2'd0,
    REG_LONG    = 2'd1,
    REG_HOLDOFF = 2'd2
  } reg_idx_e;

endpackage

### hw/rtl/button_scanner_long_press.sv
// ----------------------------------------------------------------------------
// button_scanner_long_press - polled button scanner with long press on Back
// An accepted tick request yields its result request in the next cycle.
// Throughput: one tick per cycle unless stalled; the output slot frees in the
// same cycle it is taken, so a new tick is accepted while a result leaves.
// Reset: config registers take their reset values, no press pending, waiting.
// ----------------------------------------------------------------------------
module button_scanner_long_press (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [bslp_pkg::CfgW-1:0]    cfg_data_i,
  // tick request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         back_level_i,
  input  logic                         menu_level_i,
  input  logic                         up_level_i,
  input  logic                         down_level_i,
  input  logic                         consume_i,
  input  logic                         accept_all_i,
  // result request channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bslp_pkg::CodeW-1:0]   taken_button_o,
  output logic                         press_event_o,
  output logic [bslp_pkg::CodeW-1:0]   pending_button_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [bslp_pkg::PollW-1:0] poll_q;
  logic [bslp_pkg::LongW-1:0] long_q;
  logic [bslp_pkg::HoldW-1:0] holdoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_q    <= bslp_pkg::PollReset;
      long_q    <= bslp_pkg::LongReset;
      holdoff_q <= bslp_pkg::HoldoffReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bslp_pkg::REG_POLL:    poll_q    <= cfg_data_i[bslp_pkg::PollW-1:0];
        bslp_pkg::REG_LONG:    long_q    <= cfg_data_i[bslp_pkg::LongW-1:0];
        bslp_pkg::REG_HOLDOFF: holdoff_q <= cfg_data_i[bslp_pkg::HoldW-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Scanner state
  // --------------------------------------------------------------------------
  bslp_pkg::mode_e            mode_q, mode_d;
  logic [bslp_pkg::WaitW-1:0] wait_q, wait_d;
  logic [bslp_pkg::LongW-1:0] hold_q, hold_d;
  bslp_pkg::code_e            pend_q, pend_d;

  // Result register
  logic                       out_valid_q;
  bslp_pkg::code_e            taken_q, taken_d;
  logic                       event_q, event_d;

  // Accept a tick whenever the result slot is empty or drains this cycle.
  logic in_accept;
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // Reload values for the wait counter; the sum always fits in 13 bits.
  logic [bslp_pkg::WaitW-1:0] reload_poll;
  logic [bslp_pkg::WaitW-1:0] reload_repeat;
  assign reload_poll   = {1'b0, poll_q};
  assign reload_repeat = reload_poll + {1'b0, holdoff_q};

  // Saturating increment of the hold counter.
  logic [bslp_pkg::LongW-1:0] hold_inc;
  assign hold_inc = (hold_q != '1) ? hold_q + 1'b1 : hold_q;

  bslp_pkg::code_e pend_mid;
  logic            take_ok;

  always_comb begin
    // Consume acts first on the code pending at the start of the tick.
    // A pending Back is only handed out when all buttons are accepted.
    take_ok  = consume_i & (accept_all_i | (pend_q != bslp_pkg::CODE_BACK));
    taken_d  = take_ok ? pend_q : bslp_pkg::CODE_NONE;
    pend_mid = take_ok ? bslp_pkg::CODE_NONE : pend_q;

    mode_d  = mode_q;
    wait_d  = wait_q;
    hold_d  = hold_q;
    pend_d  = pend_mid;
    event_d = 1'b0;

    unique case (mode_q)
      bslp_pkg::MODE_TIMING: begin
        if (back_level_i) begin
          // Keep timing; latch LongBack once the threshold is reached.
          hold_d = hold_inc;
          if (hold_inc >= long_q) begin
            pend_d  = bslp_pkg::CODE_LONGBACK;
            event_d = 1'b1;
            mode_d  = bslp_pkg::MODE_RELEASE;
          end
        end else begin
          // Released before the threshold: short Back.
          pend_d  = bslp_pkg::CODE_BACK;
          event_d = 1'b1;
          mode_d  = bslp_pkg::MODE_WAIT;
          wait_d  = reload_poll;
        end
      end
      bslp_pkg::MODE_RELEASE: begin
        // Hold here until Back is let go after a long press.
        if (!back_level_i) begin
          mode_d = bslp_pkg::MODE_WAIT;
          wait_d = reload_poll;
        end
      end
      default: begin
        // Waiting mode; unused codes fall in here as well.
        mode_d = bslp_pkg::MODE_WAIT;
        if (wait_q > bslp_pkg::WaitW'(1)) begin
          wait_d = wait_q - 1'b1;
        end else begin
          wait_d = reload_poll;
          if (back_level_i) begin
            // The scan itself counts as the first held tick.
            hold_d = bslp_pkg::LongW'(1);
            if (long_q <= bslp_pkg::LongW'(1)) begin
              pend_d  = bslp_pkg::CODE_LONGBACK;
              event_d = 1'b1;
              mode_d  = bslp_pkg::MODE_RELEASE;
            end else begin
              mode_d = bslp_pkg::MODE_TIMING;
            end
          end else if (menu_level_i && pend_mid != bslp_pkg::CODE_BACK) begin
            pend_d  = bslp_pkg::CODE_MENU;
            event_d = 1'b1;
            wait_d  = reload_repeat;
          end else if (up_level_i && pend_mid != bslp_pkg::CODE_MENU &&
                       pend_mid != bslp_pkg::CODE_BACK) begin
            pend_d  = bslp_pkg::CODE_UP;
            event_d = 1'b1;
            wait_d  = reload_repeat;
          end else if (down_level_i && pend_mid != bslp_pkg::CODE_UP &&
                       pend_mid != bslp_pkg::CODE_MENU &&
                       pend_mid != bslp_pkg::CODE_BACK) begin
            pend_d  = bslp_pkg::CODE_DOWN;
            event_d = 1'b1;
            wait_d  = reload_repeat;
          end
        end
      end
    endcase
  end

  // Advance the scanner state only on accepted ticks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bslp_pkg::MODE_WAIT;
      wait_q <= {1'b0, bslp_pkg::PollReset};
      hold_q <= '0;
      pend_q <= bslp_pkg::CODE_NONE;
    end else if (in_accept) begin
      mode_q <= mode_d;
      wait_q <= wait_d;
      hold_q <= hold_d;
      pend_q <= pend_d;
    end
  end

  // Result valid: set on accept, drop once taken with no new tick behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: load on accept, hold otherwise.
  bslp_pkg::code_e pend_out_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      taken_q    <= taken_d;
      event_q    <= event_d;
      pend_out_q <= pend_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign taken_button_o   = taken_q;
  assign press_event_o    = event_q;
  assign pending_button_o = pend_out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_event_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && press_event_o) |-> (pending_button_o != bslp_pkg::CODE_NONE))
    else $error("press event reported with no pending code");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while the result slot is empty");

  a_timing_hold_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == bslp_pkg::MODE_TIMING) |-> (hold_q != '0))
    else $error("timing Back with a zero hold count");

  a_event_when_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && event_d) |=> (out_valid_o && press_event_o))
    else $error("latched press did not reach the result register");

endmodule
